### rtl/cht_pkg.sv
// Shared types, constants and slot index functions for the cuckoo hash table core.
// Depends on nothing; every other file in rtl imports it.
package cht_pkg;

  // Table geometry. The second slot index starts at this key bit.
  localparam int TABLE_DEPTH  = 8192;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int SECOND_SHIFT = 16;
  localparam int KEY_W        = 64;
  localparam int PAY_W        = 16;
  localparam int CNT_W        = 8;
  localparam logic [CNT_W-1:0] MAX_DISP_RESET = CNT_W'(32);

  // Operation codes.
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // Input transaction.
  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
  } cht_req_t;

  // Result transaction.
  typedef struct packed {
    logic             found;
    logic             insert_failed;
    logic [KEY_W-1:0] result_key;
    logic [PAY_W-1:0] result_payload;
  } cht_rsp_t;

  // One word of the slot memory.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // Read address selection.
  typedef enum logic [1:0] {
    RD_FIRST  = 2'd0,
    RD_SECOND = 2'd1,
    RD_AT     = 2'd2
  } rd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    keep_a;
    logic    swap;
    logic    emit_lookup;
    logic    emit_ins_ok;
    logic    emit_ins_fail;
  } cht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic new_insert;
    logic limit_hit;
    logic rd_valid;
  } cht_stat_t;

  // The first slot is the low key bits.
  function automatic idx_t first_slot(input logic [KEY_W-1:0] key);
    return key[IDX_W-1:0];
  endfunction

  // The second slot is the key bits from SECOND_SHIFT upwards.
  function automatic idx_t second_slot(input logic [KEY_W-1:0] key);
    return key[SECOND_SHIFT +: IDX_W];
  endfunction

endpackage

### rtl/cht_ctrl.sv
// Controller state machine for the cuckoo hash table core.
// Depends on cht_pkg for the command and status structs.
module cht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cht_pkg::cht_stat_t stat,
  output cht_pkg::cht_cmd_t  cmd,
  output logic               busy
);
  import cht_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LK_A  = 7'b0000100,
    S_LK_B  = 7'b0001000,
    S_LK_C  = 7'b0010000,
    S_IN_RD = 7'b0100000,
    S_IN_WR = 7'b1000000
  } state_t;

  state_t state, state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_AT;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.new_insert ? S_IN_RD : S_LK_A;
        end
      end
      S_LK_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FIRST;
        state_next = S_LK_B;
      end
      S_LK_B: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SECOND;
        cmd.keep_a = 1'b1;
        state_next = S_LK_C;
      end
      S_LK_C: begin
        cmd.emit_lookup = 1'b1;
        state_next      = S_IDLE;
      end
      S_IN_RD: begin
        // The swap budget is checked before each read of the chase.
        if (stat.limit_hit) begin
          cmd.emit_ins_fail = 1'b1;
          state_next        = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_AT;
          state_next = S_IN_WR;
        end
      end
      S_IN_WR: begin
        cmd.swap = 1'b1;
        if (stat.rd_valid) begin
          state_next = S_IN_RD;
        end else begin
          cmd.emit_ins_ok = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

### rtl/cht_datapath.sv
// Datapath of the cuckoo hash table core: slot memory, carried entry, counters, result.
// Depends on cht_pkg for types, slot functions and constants.
module cht_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  cht_pkg::cht_req_t       req,
  input  logic                    cfg_valid,
  input  logic [cht_pkg::CNT_W-1:0] cfg_data,
  input  cht_pkg::cht_cmd_t       cmd,
  output cht_pkg::cht_stat_t      stat,
  output logic                    done,
  output cht_pkg::cht_rsp_t       rsp
);
  import cht_pkg::*;

  // Slot memory with valid bit in each word.
  slot_t mem [TABLE_DEPTH];
  slot_t rd_word;

  logic [CNT_W-1:0] max_disp;
  logic [CNT_W-1:0] swaps;
  idx_t             clr_idx;
  idx_t             at;
  logic [KEY_W-1:0] carry_key;
  logic [PAY_W-1:0] carry_pay;
  logic             hit_a;
  logic [PAY_W-1:0] pay_a;

  idx_t  rd_addr;
  idx_t  wr_addr;
  slot_t wr_word;
  logic  wr_en;
  logic  hit_b;
  idx_t  other;

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST:  rd_addr = first_slot(carry_key);
      RD_SECOND: rd_addr = second_slot(carry_key);
      default:   rd_addr = at;
    endcase
  end

  // Writes come from the clearing pass or from a swap.
  always_comb begin
    wr_en   = cmd.clr_step | cmd.swap;
    wr_addr = cmd.clr_step ? clr_idx : at;
    wr_word = '0;
    if (!cmd.clr_step) begin
      wr_word.valid   = 1'b1;
      wr_word.key     = carry_key;
      wr_word.payload = carry_pay;
    end
  end

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // The displaced occupant moves to whichever of its slots it was not in.
  assign other = (first_slot(rd_word.key) == at) ? second_slot(rd_word.key)
                                                 : first_slot(rd_word.key);
  assign hit_b = rd_word.valid && (rd_word.key == carry_key);

  // Configuration register; the port always accepts.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_disp <= MAX_DISP_RESET;
    end else if (cfg_valid) begin
      max_disp <= cfg_data;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + idx_t'(1);
    end
  end

  // Carried entry, chase position and swap count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      carry_key <= req.entry_key;
      carry_pay <= req.entry_payload;
      at        <= first_slot(req.entry_key);
      swaps     <= '0;
    end else if (cmd.swap) begin
      carry_key <= rd_word.key;
      carry_pay <= rd_word.payload;
      at        <= other;
      swaps     <= swaps + CNT_W'(1);
    end
    if (cmd.keep_a) begin
      hit_a <= rd_word.valid && (rd_word.key == carry_key);
      pay_a <= rd_word.payload;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_lookup | cmd.emit_ins_ok | cmd.emit_ins_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_lookup) begin
      rsp.found          <= hit_a | hit_b;
      rsp.insert_failed  <= 1'b0;
      rsp.result_key     <= '0;
      rsp.result_payload <= hit_a ? pay_a : (hit_b ? rd_word.payload : '0);
    end else if (cmd.emit_ins_fail) begin
      rsp.found          <= 1'b0;
      rsp.insert_failed  <= 1'b1;
      rsp.result_key     <= carry_key;
      rsp.result_payload <= carry_pay;
    end else if (cmd.emit_ins_ok) begin
      rsp <= '0;
    end
  end

  // Status back to the controller.
  assign stat.clr_last   = (clr_idx == {IDX_W{1'b1}});
  assign stat.new_insert = (req.operation == OP_INSERT);
  assign stat.limit_hit  = (swaps == max_disp);
  assign stat.rd_valid   = rd_word.valid;

endmodule

### rtl/cuckoo_hash_table_core.sv
// Channel    Signals                         Direction  Transaction when
// request    start, busy, req                in         start high and busy low
// result     done, rsp                       out        done high (one cycle, no stall)
// config     cfg_valid, cfg_ready, cfg_data  in         cfg_valid and cfg_ready high
//
// A lookup keeps busy high after acceptance while it reads the first slot, then the second slot,
// and then forms the result. An insert keeps busy high for each swap, plus a final check when
// the swap limit ends it; the next item may start once busy is low again. Each swap is
// a registered read of the slot memory followed by the write of the carried entry.
// After reset a clearing pass writes all 8192 slots (one slot a cycle) and holds busy high.
// The result is registered and appears in the cycle after the last busy cycle; the receiver cannot stall it.
//
// Top level of the cuckoo hash table core; instantiates cht_ctrl and cht_datapath.
// Depends on cht_pkg.
module cuckoo_hash_table_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  cht_pkg::cht_req_t         req,
  output logic                      done,
  output cht_pkg::cht_rsp_t         rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cht_pkg::CNT_W-1:0] cfg_data
);
  import cht_pkg::*;

  cht_cmd_t  cmd;
  cht_stat_t stat;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  cht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cht_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
